/* hw/rtl/slpg_pkg.sv */
`timescale 1ns / 1ps

package slpg_pkg;

  // Requested status codes.
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_HOLDING  = 3'd1,
    ST_PAIRING  = 3'd2,
    ST_LINKED   = 3'd3,
    ST_JOINING  = 3'd4,
    ST_ONLINE   = 3'd5,
    ST_FAILED   = 3'd6,
    ST_IDLE_ALT = 3'd7
  } status_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_DIM    = 1'b0,
    CFG_BRIGHT = 1'b1
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SETUP,
    CS_DIV,
    CS_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] hold_percent;
    logic [2:0] pulse_requests;
  } slpg_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } slpg_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
  } dp_sts_t;

  localparam int TICK_LEN_MS_DEF  = 20;
  localparam int PULSE_LIMIT_DEF  = 3;
  localparam int PULSE_LEN_MS_DEF = 60;

  localparam logic [7:0] DIM_RESET    = 8'd20;
  localparam logic [7:0] BRIGHT_RESET = 8'd60;

  localparam int PHASE_W = 32;
  localparam int DIVS_W  = 11;
  localparam int CNT_W   = 5;

  localparam logic [6:0]        PCT_MAX     = 7'd100;
  localparam logic [DIVS_W-1:0] HOLD_BASE   = 11'd320;
  // Multiply by this and drop 16 bits to divide a value of at most 1200 by five.
  localparam logic [14:0]       DIV5_RECIP  = 15'd13108;
  localparam logic [DIVS_W-1:0] PAIR_PERIOD = 11'd1000;
  localparam logic [DIVS_W-1:0] PAIR_ON     = 11'd500;
  localparam logic [DIVS_W-1:0] JOIN_PERIOD = 11'd400;
  localparam logic [DIVS_W-1:0] JOIN_ON     = 11'd200;
  localparam logic [DIVS_W-1:0] FAIL_PERIOD = 11'd2000;
  localparam logic [DIVS_W-1:0] FAIL_ON     = 11'd1600;
  localparam logic [PHASE_W-1:0] LINK_T1    = 32'd120;
  localparam logic [PHASE_W-1:0] LINK_T2    = 32'd240;
  localparam logic [PHASE_W-1:0] LINK_T3    = 32'd360;

endpackage

/* hw/rtl/slpg_ctrl.sv */
`timescale 1ns / 1ps

module slpg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  slpg_pkg::dp_sts_t sts_i,
  output slpg_pkg::dp_cmd_t cmd_o
);
  import slpg_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        can_finish;

  assign can_finish = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE:   if (in_valid_i) state_d = CS_SETUP;
      CS_SETUP:  state_d = CS_DIV;
      CS_DIV:    if (sts_i.div_last) state_d = CS_FINISH;
      CS_FINISH: if (can_finish) state_d = CS_IDLE;
      default:   state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    in_stall_o   = (state_q != CS_IDLE);
    cmd_o.load   = (state_q == CS_IDLE) && in_valid_i;
    cmd_o.setup  = (state_q == CS_SETUP);
    cmd_o.step   = (state_q == CS_DIV);
    cmd_o.finish = (state_q == CS_FINISH) && can_finish;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/slpg_dp.sv */
`timescale 1ns / 1ps

module slpg_dp #(
  parameter int TICK_LEN_MS  = slpg_pkg::TICK_LEN_MS_DEF,
  parameter int PULSE_LIMIT  = slpg_pkg::PULSE_LIMIT_DEF,
  parameter int PULSE_LEN_MS = slpg_pkg::PULSE_LEN_MS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slpg_pkg::dp_cmd_t   cmd_i,
  output slpg_pkg::dp_sts_t   sts_o,
  input  slpg_pkg::slpg_in_t  in_data_i,
  output slpg_pkg::slpg_out_t out_data_o,
  input  logic                cfg_we_i,
  input  slpg_pkg::cfg_idx_e  cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import slpg_pkg::*;

  localparam int PulseTicksRaw = PULSE_LEN_MS / TICK_LEN_MS;
  localparam logic [1:0] PulseTicks = (PulseTicksRaw > 3) ? 2'd3 : 2'(PulseTicksRaw);
  localparam logic [3:0] PulseLim   = 4'(PULSE_LIMIT);
  localparam logic [PHASE_W-1:0] TickLen = PHASE_W'(TICK_LEN_MS);

  // Configuration and architectural state.
  logic [7:0]         dim_q, bright_q;
  logic [2:0]         shown_q, shown_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [1:0]         ptl_q, ptl_d;
  logic [1:0]         pend_q, pend_d;

  // Per-beat work registers.
  status_e            st_w_q;
  logic [6:0]         pct_q;
  logic [PHASE_W-1:0] ph_q;
  logic [PHASE_W-1:0] dvd_q;
  logic               pulse_q, pulse_d;
  logic [DIVS_W-1:0]  divs_q, divs_d;
  logic [DIVS_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q;
  slpg_out_t          out_q, out_d;

  logic [3:0]         pend_sum;
  logic [1:0]         pend_sat;
  logic [PHASE_W-1:0] ph_use;
  logic [10:0]        pct12;
  logic [25:0]        prod;
  logic [DIVS_W:0]    trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q    <= DIM_RESET;
      bright_q <= BRIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIM:    dim_q    <= cfg_data_i;
        CFG_BRIGHT: bright_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Tick bookkeeping: pulse backlog, status change and phase advance.
  always_comb begin
    pend_sum = {2'b00, pend_q} + {1'b0, in_data_i.pulse_requests};
    pend_sat = (pend_sum > PulseLim) ? PulseLim[1:0] : pend_sum[1:0];
    shown_d  = in_data_i.status;
    ph_use   = (in_data_i.status != shown_q) ? '0 : phase_q;
    phase_d  = ph_use + TickLen;
    pend_d   = pend_sat;
    ptl_d    = ptl_q;
    pulse_d  = 1'b1;
    if (ptl_q != 2'd0) begin
      ptl_d = ptl_q - 2'd1;
    end else if (pend_sat != 2'd0) begin
      pend_d = pend_sat - 2'd1;
      ptl_d  = PulseTicks;
    end else begin
      pulse_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q <= 3'd0;
      phase_q <= '0;
      ptl_q   <= 2'd0;
      pend_q  <= 2'd0;
    end else if (cmd_i.load) begin
      shown_q <= shown_d;
      phase_q <= phase_d;
      ptl_q   <= ptl_d;
      pend_q  <= pend_d;
    end
  end

  // The hold period is 320 - floor(p * 12 / 5); the divide by five is a reciprocal.
  assign pct12 = {1'b0, pct_q, 3'b000} + {2'b00, pct_q, 2'b00};
  assign prod  = 26'(pct12 * DIV5_RECIP);

  always_comb begin
    unique case (st_w_q)
      ST_HOLDING: divs_d = HOLD_BASE - {3'b000, prod[23:16]};
      ST_JOINING: divs_d = JOIN_PERIOD;
      ST_FAILED:  divs_d = FAIL_PERIOD;
      default:    divs_d = PAIR_PERIOD;
    endcase
  end

  // Restoring remainder, one dividend bit per step.
  assign trial = {rem_q, dvd_q[PHASE_W-1]};
  assign rem_d = (trial >= {1'b0, divs_q}) ? DIVS_W'(trial - {1'b0, divs_q})
                                           : trial[DIVS_W-1:0];
  assign sts_o.div_last = (cnt_q == '1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.setup) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      st_w_q  <= status_e'(in_data_i.status);
      pct_q   <= (in_data_i.hold_percent > {1'b0, PCT_MAX}) ? PCT_MAX
                                                           : in_data_i.hold_percent[6:0];
      ph_q    <= ph_use;
      dvd_q   <= ph_use;
      pulse_q <= pulse_d;
    end
    if (cmd_i.setup) begin
      divs_q <= divs_d;
      rem_q  <= '0;
    end
    if (cmd_i.step) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[PHASE_W-2:0], 1'b0};
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  // Colour selection from the remainder and the phase.
  always_comb begin
    out_d = '0;
    if (pulse_q) begin
      out_d.blue = bright_q;
    end else begin
      unique case (st_w_q)
        ST_HOLDING: begin
          if (pct_q == PCT_MAX || rem_q < (divs_q >> 1)) out_d.blue = bright_q;
        end
        ST_PAIRING: begin
          if (rem_q < PAIR_ON) out_d.blue = bright_q;
        end
        ST_LINKED: begin
          if (ph_q < LINK_T1) out_d.blue = bright_q;
          else if (ph_q < LINK_T2) out_d.blue = 8'd0;
          else if (ph_q < LINK_T3) out_d.blue = bright_q;
          else out_d.blue = dim_q;
        end
        ST_JOINING: begin
          if (rem_q < JOIN_ON) begin
            out_d.red   = bright_q;
            out_d.green = dim_q;
          end
        end
        ST_ONLINE: out_d.green = dim_q;
        ST_FAILED: begin
          if (rem_q < FAIL_ON) out_d.red = bright_q;
        end
        default: out_d = '0;
      endcase
    end
  end

  assign out_data_o = out_q;

endmodule

/* hw/rtl/status_led_pattern_generator.sv */
`timescale 1ns / 1ps

// Status LED pattern generator. Each input beat is one display tick carrying
// the requested status, the hold progress and a count of new pulse requests;
// each produces exactly one output beat with the red, green and blue levels to
// show for that tick. The pulse backlog and phase are updated at the edge that
// accepts the beat. The result then passes through a setup step that forms the
// blink period (a single multiplier), the restoring remainder unit that reduces
// the 32-bit phase modulo the period one bit per cycle, and a final step that
// loads the output register once any earlier result is no longer stalled. The
// next beat is accepted as soon as the previous one has reached the output
// register, even while that result is still stalled downstream; no new beat is
// taken while one is in flight. The user must write the dim and bright levels
// through the plain write port only while no beat is in flight; the block
// itself does not enforce it.
module status_led_pattern_generator #(
  parameter int TICK_LEN_MS  = slpg_pkg::TICK_LEN_MS_DEF,
  parameter int PULSE_LIMIT  = slpg_pkg::PULSE_LIMIT_DEF,
  parameter int PULSE_LEN_MS = slpg_pkg::PULSE_LEN_MS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  slpg_pkg::slpg_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output slpg_pkg::slpg_out_t out_data_o,
  input  logic                cfg_we_i,
  input  slpg_pkg::cfg_idx_e  cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import slpg_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sequences accept, setup, remainder steps and output load.
  slpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds all tick state, the remainder unit and the output register.
  slpg_dp #(
    .TICK_LEN_MS  (TICK_LEN_MS),
    .PULSE_LIMIT  (PULSE_LIMIT),
    .PULSE_LEN_MS (PULSE_LEN_MS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

/* hw/rtl/slpg_checker.sv */
`timescale 1ns / 1ps

module slpg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input slpg_pkg::slpg_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input slpg_pkg::slpg_out_t out_data_o
);

  // Once a beat is taken, the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting a beat");

  // The block only turns busy because a beat was accepted.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an accepted beat");

  // A new result only appears at the end of a busy period.
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (.*);
